### rtl/core/api_frame_deframer_checksum_macros.svh
// Assertion macros shared by the frame deframer RTL.
`ifndef API_FRAME_DEFRAMER_CHECKSUM_MACROS_SVH
`define API_FRAME_DEFRAMER_CHECKSUM_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define AFDC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AFDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer next-cycle check failed");

`endif

### rtl/core/afdc_pkg.sv
// Package with the constants and phase codes of the API frame deframer.
package afdc_pkg;

   // Field widths fixed by the frame format.
   localparam int DATA_W = 8;
   localparam int LEN_W  = 7;
   localparam int IDX_W  = 6;

   // Framing constants.
   localparam logic [DATA_W-1:0] START_BYTE = 8'h7E;
   localparam logic [DATA_W-1:0] CSUM_BASE  = 8'hFF;

   // Phase codes of the receive and replay sequencer.
   localparam int PH_W = 3;
   localparam logic [PH_W-1:0] PH_HUNT    = 3'd0;
   localparam logic [PH_W-1:0] PH_LEN_HI  = 3'd1;
   localparam logic [PH_W-1:0] PH_LEN_LO  = 3'd2;
   localparam logic [PH_W-1:0] PH_PAYLOAD = 3'd3;
   localparam logic [PH_W-1:0] PH_CHECK   = 3'd4;
   localparam logic [PH_W-1:0] PH_RD      = 3'd5;
   localparam logic [PH_W-1:0] PH_LOAD    = 3'd6;

   typedef logic [DATA_W-1:0] byte_type;

endpackage

### rtl/core/api_frame_deframer_checksum.sv
// Top level of the API frame deframer with payload buffer and checksum check.

// The receiver takes one serial byte per request, one per cycle while req_stall is low. It
// hunts for the start byte 0x7E, reads a 16-bit big-endian length, and drops frames longer
// than csr_max_length (saturated at BUFFER_DEPTH). Payload bytes go into a buffer memory with
// one write port and a registered read port, and are summed on the fly. When the
// checksum byte equals 0xFF minus the low byte of that sum, the frame is replayed from the
// buffer on the rsp_ channel: each payload byte passes through a memory read, then the load
// of the output register, which waits while rsp_stall holds the output register. A valid
// empty frame gives one response with rsp_has_payload low, also after the read and load. During the
// replay req_stall is high. The buffer needs no clearing after reset: only bytes written in
// the current frame are ever read back. Configuration writes are always taken.
module api_frame_deframer_checksum #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [afdc_pkg::LEN_W-1:0]    csr_max_length,
   // Received byte channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [afdc_pkg::DATA_W-1:0]   req_rx_byte,
   // Payload replay channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [afdc_pkg::DATA_W-1:0]   rsp_payload_byte,
   output logic [afdc_pkg::IDX_W-1:0]    rsp_byte_index,
   output logic [afdc_pkg::LEN_W-1:0]    rsp_frame_length,
   output logic                          rsp_has_payload,
   output logic                          rsp_last
);
   import afdc_pkg::*;

`include "api_frame_deframer_checksum_macros.svh"

   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

   // Control and payload registers.
   logic [PH_W-1:0]   phase_ff, phase_in;
   byte_type          length_high_ff, length_high_in;
   logic [LEN_W-1:0]  frame_len_ff, frame_len_in;
   logic [LEN_W-1:0]  byte_count_ff, byte_count_in;
   byte_type          running_sum_ff, running_sum_in;
   logic [LEN_W-1:0]  max_length_ff, max_length_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   byte_type          rsp_payload_byte_ff, rsp_payload_byte_in;
   logic [IDX_W-1:0]  rsp_byte_index_ff, rsp_byte_index_in;
   logic [LEN_W-1:0]  rsp_frame_length_ff, rsp_frame_length_in;
   logic              rsp_has_payload_ff, rsp_has_payload_in;
   logic              rsp_last_ff, rsp_last_in;

   // Payload buffer and its registered read data.
   byte_type          payload_mem [BUFFER_DEPTH];
   byte_type          rd_data_ff;

   logic              req_accept;
   logic              out_free;
   logic              mem_we;
   logic [LEN_W-1:0]  limit;
   logic [2*DATA_W-1:0] len_word;
   logic              frame_empty;
   logic              replay_last;

   assign csr_ready = 1'b1;

   // Input is held off while the stored frame is replayed.
   assign req_stall  = (phase_ff == PH_RD) || (phase_ff == PH_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign limit       = (max_length_ff > DEPTH_LEN) ? DEPTH_LEN : max_length_ff;
   assign len_word    = {length_high_ff, req_rx_byte};
   assign frame_empty = (frame_len_ff == '0);
   assign replay_last = frame_empty || (({1'b0, rd_idx_ff} + LEN_W'(1)) == frame_len_ff);

   assign mem_we = req_accept && (phase_ff == PH_PAYLOAD) && (byte_count_ff < DEPTH_LEN);

   // Receive sequencer, checksum accumulation and replay control.
   always_comb begin
      phase_in            = phase_ff;
      length_high_in      = length_high_ff;
      frame_len_in        = frame_len_ff;
      byte_count_in       = byte_count_ff;
      running_sum_in      = running_sum_ff;
      rd_idx_in           = rd_idx_ff;
      max_length_in       = csr_valid ? csr_max_length : max_length_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_payload_byte_in = rsp_payload_byte_ff;
      rsp_byte_index_in   = rsp_byte_index_ff;
      rsp_frame_length_in = rsp_frame_length_ff;
      rsp_has_payload_in  = rsp_has_payload_ff;
      rsp_last_in         = rsp_last_ff;

      case (phase_ff)
         PH_LEN_HI: begin
            if (req_accept) begin
               length_high_in = req_rx_byte;
               phase_in       = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            if (req_accept) begin
               if (len_word > {{(2*DATA_W-LEN_W){1'b0}}, limit}) begin
                  phase_in = PH_HUNT;
               end else begin
                  frame_len_in   = len_word[LEN_W-1:0];
                  byte_count_in  = '0;
                  running_sum_in = '0;
                  phase_in       = (len_word == '0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (req_accept) begin
               running_sum_in = running_sum_ff + req_rx_byte;
               byte_count_in  = byte_count_ff + LEN_W'(1);
               if ((byte_count_ff + LEN_W'(1)) >= frame_len_ff) begin
                  phase_in = PH_CHECK;
               end
            end
         end
         PH_CHECK: begin
            if (req_accept) begin
               rd_idx_in = '0;
               phase_in  = ((CSUM_BASE - running_sum_ff) == req_rx_byte) ? PH_RD : PH_HUNT;
            end
         end
         PH_RD: begin
            // The buffer read issued here lands in rd_data_ff next cycle.
            phase_in = PH_LOAD;
         end
         PH_LOAD: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_payload_byte_in = frame_empty ? '0 : rd_data_ff;
               rsp_byte_index_in   = rd_idx_ff;
               rsp_frame_length_in = frame_len_ff;
               rsp_has_payload_in  = !frame_empty;
               rsp_last_in         = replay_last;
               if (replay_last) begin
                  phase_in = PH_HUNT;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
                  phase_in  = PH_RD;
               end
            end
         end
         default: begin
            if (req_accept) begin
               phase_in = (req_rx_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         length_high_ff <= '0;
         frame_len_ff   <= '0;
         byte_count_ff  <= '0;
         running_sum_ff <= '0;
         max_length_ff  <= LEN_W'(64);
         rd_idx_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         length_high_ff <= length_high_in;
         frame_len_ff   <= frame_len_in;
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         max_length_ff  <= max_length_in;
         rd_idx_ff      <= rd_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      rsp_payload_byte_ff <= rsp_payload_byte_in;
      rsp_byte_index_ff   <= rsp_byte_index_in;
      rsp_frame_length_ff <= rsp_frame_length_in;
      rsp_has_payload_ff  <= rsp_has_payload_in;
      rsp_last_ff         <= rsp_last_in;
   end

   // Payload buffer: one write port for reception, one registered read for replay.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[byte_count_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      rd_data_ff <= payload_mem[rd_idx_ff[ADDR_W-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;
   assign rsp_byte_index   = rsp_byte_index_ff;
   assign rsp_frame_length = rsp_frame_length_ff;
   assign rsp_has_payload  = rsp_has_payload_ff;
   assign rsp_last         = rsp_last_ff;

   // A byte-carrying response always lies inside its frame.
   `AFDC_ASSERT_SAME(a_index_in_frame, clock, reset, rsp_valid_ff && rsp_has_payload_ff, ({1'b0, rsp_byte_index_ff} < rsp_frame_length_ff))
   // An empty-frame response is the only and last one of a zero-length frame.
   `AFDC_ASSERT_SAME(a_empty_is_last, clock, reset, rsp_valid_ff && !rsp_has_payload_ff, rsp_last_ff && (rsp_frame_length_ff == '0))
   // The receive counter never reaches the frame length while payload is expected.
   `AFDC_ASSERT_SAME(a_count_in_range, clock, reset, phase_ff == PH_PAYLOAD, byte_count_ff < frame_len_ff)
   // Loading the last response ends the replay and reopens the input.
   `AFDC_ASSERT_NEXT(a_replay_ends, clock, reset, (phase_ff == PH_LOAD) && out_free && replay_last, !req_stall)

endmodule
